FILE: rtl/core/lcdq_pkg.sv
// Package for the paced LCD write queue: sizes, codes and pointer helpers.
package lcdq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int DELAY_W     = 16;
  localparam int CFG_IDX_W   = 1;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [DELAY_W-1:0] delay_t;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_DELAY  = 1'd0,
    REG_SHORT_DELAY = 1'd1
  } reg_idx_t;

  localparam logic [7:0] ESCAPE_BYTE  = 8'hFE;
  localparam logic [7:0] HOME_LIMIT   = 8'd4;
  localparam delay_t     LONG_RESET   = DELAY_W'(10000);
  localparam delay_t     SHORT_RESET  = DELAY_W'(250);

  // circular advance, valid for any depth
  function automatic ptr_t next_slot(input ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

FILE: rtl/core/char_lcd_paced_write_queue_top.sv
// Paced LCD write queue: handshakes, pointers, pacing timer and head-read sequencer.
// Puts write the byte, or for an instruction the escape and then the byte in S_PUT2.
// A writing tick reads the head in S_RD1, an escape's second byte in S_RD2, then waits
// in S_EMIT for a free output register. No input is taken outside S_IDLE.
// Reset clears pointers, pacing timer and out_valid; delays return to 10000 and 250 ticks.
// The byte store is not cleared; only written entries are ever read.
module char_lcd_paced_write_queue_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_operation,
  input  logic [7:0]                         in_byte_value,
  input  logic                               in_is_instruction,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_register_select,
  output logic [7:0]                         out_lcd_byte,
  input  logic                               cfg_wr_en,
  input  logic [lcdq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcdq_pkg::DELAY_W-1:0]       cfg_wr_data
);
  import lcdq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PUT2 = 5'b00010,
    S_RD1  = 5'b00100,
    S_RD2  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  ptr_t       wp_r, wp_nxt;
  ptr_t       rp_r, rp_nxt;
  delay_t     cnt_r, cnt_nxt;
  delay_t     long_r, short_r;
  ptr_t       pos_r, pos_nxt;
  ptr_t       put_idx_r, put_idx_nxt;
  ptr_t       put_after_r, put_after_nxt;
  logic [7:0] put_val_r, put_val_nxt;
  logic       res_rs_r, res_rs_nxt;
  logic [7:0] res_byte_r, res_byte_nxt;
  logic       out_valid_r;
  logic       out_rs_r;
  logic [7:0] out_byte_r;

  logic       accept;
  logic       out_free;
  logic       emit;
  logic       mem_we;
  ptr_t       mem_waddr;
  logic [7:0] mem_wdata;
  ptr_t       mem_raddr;
  logic [7:0] mem_rdata;
  ptr_t       slot1, slot2, head_next;

  lcdq_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (state_r == S_EMIT) && out_free;
  assign slot1     = next_slot(wp_r);
  assign slot2     = next_slot(slot1);
  assign head_next = next_slot(rp_r);
  assign mem_raddr = (state_r == S_RD1) ? head_next : rp_r;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    put_idx_nxt   = put_idx_r;
    put_after_nxt = put_after_r;
    put_val_nxt   = put_val_r;
    res_rs_nxt    = res_rs_r;
    res_byte_nxt  = res_byte_r;
    mem_we        = 1'b0;
    mem_waddr     = wp_r;
    mem_wdata     = in_byte_value;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_operation))
            OP_PUT: begin
              if (in_is_instruction) begin
                // escape goes first; drop whole if either slot would hit the head
                if (slot1 != rp_r && slot2 != rp_r) begin
                  mem_we        = 1'b1;
                  mem_wdata     = ESCAPE_BYTE;
                  put_idx_nxt   = slot1;
                  put_after_nxt = slot2;
                  put_val_nxt   = in_byte_value;
                  state_nxt     = S_PUT2;
                end
              end else if (slot1 != rp_r) begin
                mem_we = 1'b1;
                wp_nxt = slot1;
              end
            end
            OP_TICK: begin
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - 1'b1;
              end else if (rp_r != wp_r) begin
                state_nxt = S_RD1;
              end
            end
            OP_FLUSH: begin
              wp_nxt = '0;
              rp_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_PUT2: begin
        mem_we    = 1'b1;
        mem_waddr = put_idx_r;
        mem_wdata = put_val_r;
        wp_nxt    = put_after_r;
        state_nxt = S_IDLE;
      end
      S_RD1: begin
        if (mem_rdata == ESCAPE_BYTE) begin
          // lone escape waits for the byte behind it
          if (head_next == wp_r) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = head_next;
            state_nxt = S_RD2;
          end
        end else begin
          res_rs_nxt   = 1'b1;
          res_byte_nxt = mem_rdata;
          pos_nxt      = rp_r;
          state_nxt    = S_EMIT;
        end
      end
      S_RD2: begin
        res_rs_nxt   = 1'b0;
        res_byte_nxt = mem_rdata;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          rp_nxt    = next_slot(pos_r);
          cnt_nxt   = (!res_rs_r && res_byte_r < HOME_LIMIT) ? long_r : short_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r  <= LONG_RESET;
      short_r <= SHORT_RESET;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_LONG_DELAY:  long_r  <= cfg_wr_data;
        REG_SHORT_DELAY: short_r <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    put_idx_r   <= put_idx_nxt;
    put_after_r <= put_after_nxt;
    put_val_r   <= put_val_nxt;
    res_rs_r    <= res_rs_nxt;
    res_byte_r  <= res_byte_nxt;
    if (emit) begin
      out_rs_r   <= res_rs_r;
      out_byte_r <= res_byte_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = out_rs_r;
  assign out_lcd_byte        = out_byte_r;

  // a head read is only started on a non-empty queue
  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD1 |-> rp_r != wp_r)
    else $error("head read on empty queue");

  // second half of an instruction put lands the saved write pointer
  a_put2_wp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUT2 |=> wp_r == $past(put_after_r))
    else $error("write pointer not advanced after instruction put");

  // a finished result reaches the output register on the next edge
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && out_byte_r == $past(res_byte_r))
    else $error("result not transferred to output");

  // the output state is only entered from a head read
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> $past(state_r) == S_RD1 || $past(state_r) == S_RD2
                          || $past(state_r) == S_EMIT)
    else $error("unexpected entry to output state");

endmodule

FILE: rtl/core/lcdq_store.sv
// Queue byte store: one write port, one read port, registered read data.
module lcdq_store (
  input  logic              clk,
  input  logic              we,
  input  lcdq_pkg::ptr_t    waddr,
  input  logic [7:0]        wdata,
  input  lcdq_pkg::ptr_t    raddr,
  output logic [7:0]        rdata
);
  import lcdq_pkg::*;

  logic [7:0] mem [QUEUE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
